// ===== sv/nsi_pkg.sv =====
// Package for the top-N sorted insertion block.
// Holds the item and result transaction types, controller states and command/status groups.
// Depends on nothing; every other file of the block but nsi_ram uses it.
`default_nettype none

package nsi_pkg;

	localparam int LIST_LENGTH_DEF = 8;
	localparam int LIST_COUNT_DEF = 4;

	localparam int SCORE_W = 32;
	localparam int RANK_W = 3;
	localparam int POS_W = 3;
	localparam int TABLE_W = 2;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic kind;
		logic [TABLE_W-1:0] table_index;
		logic [POS_W-1:0] position;
		logic [SCORE_W-1:0] score_value;
	} item_t;

	typedef struct packed {
		logic placed;
		logic [RANK_W-1:0] rank;
		logic entry_valid;
		logic [SCORE_W-1:0] entry_value;
	} result_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_READ = 5'b00100,
		ST_FIN = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic read;
		logic finish;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_read;
		logic list_ok;
		logic empty;
		logic scan_done;
	} sts_t;

	function automatic int clog2_min1(input int v);
		return (v > 1) ? $clog2(v) : 1;
	endfunction

endpackage

`default_nettype wire

// ===== sv/nsi_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing.
`default_nettype none

module nsi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/nsi_datapath.sv =====
// Datapath of the top-N sorted insertion block: score memory, per-list fill counts,
// backward insertion scan and the result registers. Depends on nsi_pkg and nsi_ram.
`default_nettype none

module nsi_datapath #(
	parameter int LIST_LENGTH = nsi_pkg::LIST_LENGTH_DEF,
	parameter int LIST_COUNT = nsi_pkg::LIST_COUNT_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire nsi_pkg::item_t item,
	input wire nsi_pkg::cmd_t cmd,
	output nsi_pkg::sts_t sts,
	output nsi_pkg::result_t result
);

	localparam int DEPTH = LIST_LENGTH * LIST_COUNT;
	localparam int AW = nsi_pkg::clog2_min1(DEPTH);
	localparam int IW = nsi_pkg::clog2_min1(LIST_LENGTH);
	localparam int CW = $clog2(LIST_LENGTH + 1);
	localparam int LW = nsi_pkg::clog2_min1(LIST_COUNT);

	logic [CW-1:0] count_q [LIST_COUNT];
	logic [LW-1:0] lidx;
	logic list_ok_c;
	logic [CW-1:0] n_in;

	logic kind_q;
	logic ok_q;
	logic [LW-1:0] list_q;
	logic [nsi_pkg::POS_W-1:0] pos_q;
	logic [nsi_pkg::SCORE_W-1:0] score_q;
	logic [AW-1:0] base_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] rem_q;
	logic [CW-1:0] p_q;
	logic pend_s1;
	logic [IW-1:0] idx_s1;
	nsi_pkg::result_t res_q;
	nsi_pkg::result_t out_q;

	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [nsi_pkg::SCORE_W-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [nsi_pkg::SCORE_W-1:0] ram_rdata;

	logic less;
	logic stop;
	logic [CW-1:0] next_idx;
	logic shift_we;
	logic place;
	logic fin_we;
	logic pos_ok;
	logic pos_filled;

	assign list_ok_c = int'(item.table_index) < LIST_COUNT;
	assign lidx = LW'(item.table_index);
	assign n_in = list_ok_c ? count_q[lidx] : '0;

	assign sts.is_read = (item.kind == nsi_pkg::KIND_READ);
	assign sts.list_ok = list_ok_c;
	assign sts.empty = (n_in == '0);

	assign less = score_q < ram_rdata;
	assign next_idx = CW'(idx_s1) + CW'(1);
	assign stop = pend_s1 && (!less || (idx_s1 == '0));
	assign sts.scan_done = cmd.scan && stop;

	assign shift_we = cmd.scan && pend_s1 && less && (next_idx < CW'(LIST_LENGTH));
	assign place = p_q < CW'(LIST_LENGTH);
	assign fin_we = cmd.finish && (kind_q == nsi_pkg::KIND_INSERT) && ok_q && place;

	assign pos_ok = int'(pos_q) < LIST_LENGTH;
	assign pos_filled = int'(pos_q) < int'(n_q);

	always_comb begin
		ram_we = shift_we || fin_we;
		if (shift_we) begin
			ram_waddr = base_q + AW'(next_idx);
			ram_wdata = ram_rdata;
		end else begin
			ram_waddr = base_q + AW'(p_q);
			ram_wdata = score_q;
		end
		if (cmd.read) begin
			ram_raddr = base_q + AW'(pos_q);
		end else begin
			ram_raddr = base_q + AW'(rem_q - CW'(1));
		end
	end

	nsi_ram #(
		.WIDTH(nsi_pkg::SCORE_W),
		.DEPTH(DEPTH)
	) u_score_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
			for (int i = 0; i < LIST_COUNT; i++) begin
				count_q[i] <= '0;
			end
		end else begin
			if (cmd.load) begin
				pend_s1 <= 1'b0;
			end else if (cmd.scan) begin
				pend_s1 <= !stop && (rem_q != '0);
			end
			if (fin_we) begin
				count_q[list_q] <= (n_q == CW'(LIST_LENGTH)) ? n_q : n_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= item.kind;
			ok_q <= list_ok_c;
			list_q <= lidx;
			pos_q <= item.position;
			score_q <= item.score_value;
			base_q <= AW'(int'(lidx) * LIST_LENGTH);
			n_q <= n_in;
			rem_q <= n_in;
			p_q <= '0;
		end else if (cmd.scan) begin
			if (!stop && (rem_q != '0)) begin
				idx_s1 <= IW'(rem_q - CW'(1));
				rem_q <= rem_q - CW'(1);
			end
			if (stop) begin
				p_q <= less ? '0 : next_idx;
			end
		end
		if (cmd.finish) begin
			if (kind_q == nsi_pkg::KIND_READ) begin
				res_q.placed <= 1'b0;
				res_q.rank <= '0;
				res_q.entry_valid <= ok_q && pos_ok && pos_filled;
				res_q.entry_value <= (ok_q && pos_ok && pos_filled) ? ram_rdata : '0;
			end else begin
				res_q.placed <= ok_q && place;
				res_q.rank <= (ok_q && place) ? nsi_pkg::RANK_W'(p_q) : '0;
				res_q.entry_valid <= 1'b0;
				res_q.entry_value <= '0;
			end
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	assign result = out_q;

	a_no_write_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && (kind_q == nsi_pkg::KIND_READ)) |-> !ram_we)
		else $error("Memory written while finishing a read transaction.");

	a_pend_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> $past(cmd.scan))
		else $error("Scan read pending outside of a scan.");

	a_result_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> !(result.placed && result.entry_valid))
		else $error("Result reports both a placement and a read entry.");

endmodule

`default_nettype wire

// ===== sv/nsi_ctrl.sv =====
// Controller of the top-N sorted insertion block: one-hot state machine that sequences
// the datapath and owns both handshakes. Depends on nsi_pkg.
`default_nettype none

module nsi_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_stall,
	output logic result_valid,
	input wire logic result_stall,
	input wire nsi_pkg::sts_t sts,
	output nsi_pkg::cmd_t cmd
);

	nsi_pkg::state_t state_q;
	nsi_pkg::state_t state_nxt;
	logic rv_q;

	assign item_stall = (state_q != nsi_pkg::ST_IDLE);
	assign result_valid = rv_q;

	assign cmd.load = (state_q == nsi_pkg::ST_IDLE) && item_valid;
	assign cmd.scan = (state_q == nsi_pkg::ST_SCAN);
	assign cmd.read = (state_q == nsi_pkg::ST_READ);
	assign cmd.finish = (state_q == nsi_pkg::ST_FIN);
	assign cmd.out_load = (state_q == nsi_pkg::ST_DONE) && (!rv_q || !result_stall);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			nsi_pkg::ST_IDLE: begin
				if (cmd.load) begin
					if (sts.is_read) begin
						state_nxt = nsi_pkg::ST_READ;
					end else if (sts.list_ok && !sts.empty) begin
						state_nxt = nsi_pkg::ST_SCAN;
					end else begin
						state_nxt = nsi_pkg::ST_FIN;
					end
				end
			end
			nsi_pkg::ST_SCAN: begin
				if (sts.scan_done) begin
					state_nxt = nsi_pkg::ST_FIN;
				end
			end
			nsi_pkg::ST_READ: begin
				state_nxt = nsi_pkg::ST_FIN;
			end
			nsi_pkg::ST_FIN: begin
				state_nxt = nsi_pkg::ST_DONE;
			end
			nsi_pkg::ST_DONE: begin
				if (cmd.out_load) begin
					state_nxt = nsi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = nsi_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nsi_pkg::ST_IDLE;
			rv_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				rv_q <= 1'b1;
			end else if (!result_stall) begin
				rv_q <= 1'b0;
			end
		end
	end

	a_load_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q != nsi_pkg::ST_IDLE))
		else $error("Controller stayed idle after accepting a transaction.");

	a_fin_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nsi_pkg::ST_FIN) |=> (state_q == nsi_pkg::ST_DONE))
		else $error("Finish step did not hand over to the result step.");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> result_valid)
		else $error("Result transaction dropped while stalled.");

endmodule

`default_nettype wire

// ===== sv/top_n_sorted_insert.sv =====
// Top level of the top-N sorted insertion block. From accepted item to result valid, a read
// passes READ, FIN and DONE; an insert passes SCAN first if its list is non-empty, then FIN
// and DONE, the backward scan via the single read port of the score memory, one entry a cycle.
// The next item can be accepted in the cycle after the result enters the output register.
// Reset is asynchronous and active low; it empties every list through the fill counts at once.
// Depends on nsi_pkg, nsi_ctrl, nsi_datapath and nsi_ram.
`default_nettype none

module top_n_sorted_insert #(
	parameter int LIST_LENGTH = nsi_pkg::LIST_LENGTH_DEF,
	parameter int LIST_COUNT = nsi_pkg::LIST_COUNT_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_stall,
	input wire nsi_pkg::item_t item,
	output logic result_valid,
	input wire logic result_stall,
	output nsi_pkg::result_t result
);

	nsi_pkg::cmd_t cmd;
	nsi_pkg::sts_t sts;

	nsi_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.sts(sts),
		.cmd(cmd)
	);

	nsi_datapath #(
		.LIST_LENGTH(LIST_LENGTH),
		.LIST_COUNT(LIST_COUNT)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.cmd(cmd),
		.sts(sts),
		.result(result)
	);

endmodule

`default_nettype wire

// ===== tb/sv/tb_top_n_sorted_insert.sv =====
// Self-checking testbench for top_n_sorted_insert: a table of directed transactions and then
// random inserts and reads, checked against table results or a predictor of the ranked lists.
// Depends on nsi_pkg and the top_n_sorted_insert RTL.
`timescale 1ns / 100ps

module tb_top_n_sorted_insert;

	localparam int LIST_LENGTH = nsi_pkg::LIST_LENGTH_DEF;
	localparam int LIST_COUNT = nsi_pkg::LIST_COUNT_DEF;
	localparam int RANDOM_ITEMS = 1500;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		nsi_pkg::item_t stim;
		bit typed;
		nsi_pkg::result_t want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	nsi_pkg::item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	nsi_pkg::result_t result;

	logic [nsi_pkg::SCORE_W-1:0] board_score [LIST_COUNT][LIST_LENGTH];
	bit board_valid [LIST_COUNT][LIST_LENGTH];
	int list_fill [LIST_COUNT];
	nsi_pkg::result_t expected_results [$];
	step_t directed_plan [$];
	int gap_pct = 10;
	int stall_pct = 77;
	int error_count = 0;
	int quiet_cycles = 0;

	top_n_sorted_insert dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic nsi_pkg::result_t predict_ranking(input nsi_pkg::item_t it);
		nsi_pkg::result_t r;
		int tbl;
		int slot;
		int i;
		int j;
		r = '0;
		tbl = it.table_index;
		if (tbl >= LIST_COUNT)
			return r;
		if (it.kind == nsi_pkg::KIND_INSERT) begin
			slot = LIST_LENGTH;
			for (i = 0; i < LIST_LENGTH; i++)
				if (slot == LIST_LENGTH &&
						(!board_valid[tbl][i] || it.score_value < board_score[tbl][i]))
					slot = i;
			if (slot < LIST_LENGTH) begin
				for (j = LIST_LENGTH - 1; j > slot; j--) begin
					board_score[tbl][j] = board_score[tbl][j-1];
					board_valid[tbl][j] = board_valid[tbl][j-1];
				end
				board_score[tbl][slot] = it.score_value;
				board_valid[tbl][slot] = 1'b1;
				if (list_fill[tbl] < LIST_LENGTH)
					list_fill[tbl]++;
				r.placed = 1'b1;
				r.rank = nsi_pkg::RANK_W'(slot);
			end
		end else if (it.position < LIST_LENGTH && board_valid[tbl][it.position]) begin
			r.entry_valid = 1'b1;
			r.entry_value = board_score[tbl][it.position];
		end
		return r;
	endfunction

	function automatic void add_step(input logic k, input int tbl, input int pos,
			input logic [nsi_pkg::SCORE_W-1:0] score, input bit typed, input logic pl,
			input int rk, input logic ev, input logic [nsi_pkg::SCORE_W-1:0] val);
		step_t s;
		s.stim.kind = k;
		s.stim.table_index = nsi_pkg::TABLE_W'(tbl);
		s.stim.position = nsi_pkg::POS_W'(pos);
		s.stim.score_value = score;
		s.typed = typed;
		s.want.placed = pl;
		s.want.rank = nsi_pkg::RANK_W'(rk);
		s.want.entry_valid = ev;
		s.want.entry_value = val;
		directed_plan.push_back(s);
	endfunction

	task automatic send_item(input nsi_pkg::item_t it, input bit typed,
			input nsi_pkg::result_t want);
		nsi_pkg::result_t predicted;
		int gap;
		gap = 0;
		while ($urandom_range(99) < gap_pct)
			gap++;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		predicted = predict_ranking(it);
		expected_results.push_back(typed ? want : predicted);
		item <= it;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (item_stall !== 1'b0);
	endtask

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin : check_results
		nsi_pkg::result_t want;
		if (arst_n && result_valid === 1'b1 && result_stall == 1'b0) begin
			if (expected_results.size() == 0) begin
				$error("result transaction with no pending expectation");
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (result.placed !== want.placed) begin
					$error("placed: expected %0d, got %0d", want.placed, result.placed);
					error_count++;
				end
				if (result.rank !== want.rank) begin
					$error("rank: expected %0d, got %0d", want.rank, result.rank);
					error_count++;
				end
				if (result.entry_valid !== want.entry_valid) begin
					$error("entry_valid: expected %0d, got %0d", want.entry_valid,
						result.entry_valid);
					error_count++;
				end
				if (result.entry_value !== want.entry_value) begin
					$error("entry_value: expected %h, got %h", want.entry_value,
						result.entry_value);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		nsi_pkg::item_t it;
		int n;
		int tbl;
		int fill;
		for (tbl = 0; tbl < LIST_COUNT; tbl++) begin
			list_fill[tbl] = 0;
			for (n = 0; n < LIST_LENGTH; n++) begin
				board_score[tbl][n] = '0;
				board_valid[tbl][n] = 1'b0;
			end
		end

		add_step(nsi_pkg::KIND_READ, 0, 0, 32'h0, 1, 1'b0, 0, 1'b0, 32'h0);
		add_step(nsi_pkg::KIND_INSERT, 0, 0, 32'h0001_0000, 1, 1'b1, 0, 1'b0, 32'h0);
		add_step(nsi_pkg::KIND_READ, 0, 0, 32'h0, 1, 1'b0, 0, 1'b1, 32'h0001_0000);
		add_step(nsi_pkg::KIND_INSERT, 0, 0, 32'hFFFF_FFFF, 1, 1'b1, 1, 1'b0, 32'h0);
		add_step(nsi_pkg::KIND_INSERT, 0, 0, 32'h0000_0000, 1, 1'b1, 0, 1'b0, 32'h0);
		add_step(nsi_pkg::KIND_INSERT, 0, 7, 32'h0001_0000, 0, 1'b0, 0, 1'b0, 32'h0);
		add_step(nsi_pkg::KIND_READ, 0, 3, 32'hFFFF_FFFF, 0, 1'b0, 0, 1'b0, 32'h0);
		for (n = LIST_LENGTH; n >= 1; n--)
			add_step(nsi_pkg::KIND_INSERT, 1, n - 1, 32'(n * 16), 0, 1'b0, 0, 1'b0, 32'h0);
		add_step(nsi_pkg::KIND_INSERT, 1, 0, 32'hFFFF_FFFF, 1, 1'b0, 0, 1'b0, 32'h0);
		add_step(nsi_pkg::KIND_INSERT, 1, 0, 32'h0000_0080, 1, 1'b0, 0, 1'b0, 32'h0);
		add_step(nsi_pkg::KIND_INSERT, 1, 0, 32'h0000_007F, 0, 1'b0, 0, 1'b0, 32'h0);
		add_step(nsi_pkg::KIND_READ, 1, 7, 32'h0, 0, 1'b0, 0, 1'b0, 32'h0);
		add_step(nsi_pkg::KIND_INSERT, 2, 0, 32'hFFFF_FFFF, 1, 1'b1, 0, 1'b0, 32'h0);
		add_step(nsi_pkg::KIND_INSERT, 3, 5, 32'h0000_0000, 1, 1'b1, 0, 1'b0, 32'h0);
		add_step(nsi_pkg::KIND_READ, 3, 0, 32'h0, 1, 1'b0, 0, 1'b1, 32'h0);
		add_step(nsi_pkg::KIND_READ, 2, 0, 32'h0, 1, 1'b0, 0, 1'b1, 32'hFFFF_FFFF);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < directed_plan.size(); n++)
			send_item(directed_plan[n].stim, directed_plan[n].typed, directed_plan[n].want);

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3) begin
				gap_pct = 77;
				stall_pct = 10;
			end else if (n == 2 * RANDOM_ITEMS / 3) begin
				gap_pct = 0;
				stall_pct = 0;
			end
			tbl = $urandom_range(LIST_COUNT - 1);
			fill = list_fill[tbl];
			it.table_index = nsi_pkg::TABLE_W'(tbl);
			it.position = nsi_pkg::POS_W'($urandom);
			it.score_value = $urandom;
			if ($urandom_range(99) < 30) begin
				it.kind = nsi_pkg::KIND_READ;
				if (fill > 0 && $urandom_range(3) != 0)
					it.position = nsi_pkg::POS_W'($urandom_range(fill - 1));
			end else begin
				it.kind = nsi_pkg::KIND_INSERT;
				case ($urandom_range(5))
					0: ;
					1: it.score_value = $urandom_range(255);
					2: it.score_value = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
					3, 4: begin
						if (fill > 0)
							it.score_value = board_score[tbl][$urandom_range(fill - 1)]
								+ $urandom_range(2) - 1;
					end
					default: it.score_value = {16'($urandom_range(3)), 16'($urandom)};
				endcase
			end
			send_item(it, 1'b0, '0);
		end
		item_valid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
